// ===== rtl/ffd_pkg.sv =====
package ffd_pkg;

    // Item and register field widths
    localparam int SAMPLE_W = 24;
    localparam int CH_IN_W  = 3;
    localparam int DELAY_W  = 20;
    localparam int FB_W     = 15;
    localparam int MIX_W    = 16;
    localparam int FRAC_W   = 8;

    // APB configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_DELAY = 2'd0;
    localparam logic [1:0] REG_FB    = 2'd1;
    localparam logic [1:0] REG_MIX   = 2'd2;

    localparam logic [FB_W-1:0]  FB_MAX  = FB_W'(32735);
    localparam logic [MIX_W-1:0] MIX_MAX = MIX_W'(32768);

    // Shared multiplier and its product
    localparam int DIFF_W  = SAMPLE_W + 1;
    localparam int MUL_A_W = SAMPLE_W + 2;
    localparam int MUL_B_W = MIX_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic signed [PROD_W-1:0] RND8   = PROD_W'(128);
    localparam logic signed [PROD_W-1:0] RND15  = PROD_W'(16384);
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(8388607);
    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-8388608);

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [FB_W-1:0]    fb;
        logic [MIX_W-1:0]   mix;
    } t_cfg;

    // Microcode fields
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_WAIT_OUT,
        SEQ_JUMP
    } t_seq_op;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_I0,
        RD_I1
    } t_rd_sel;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_INTERP,
        MUL_FB,
        MUL_DRY,
        MUL_WET
    } t_mul_sel;

    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_LATCH,
        ALU_POS,
        ALU_I1,
        ALU_D0,
        ALU_DIFF,
        ALU_DLY,
        ALU_STORE,
        ALU_ACC,
        ALU_OUT
    } t_alu_op;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_IDLE   = 4'd0;
    localparam t_step STEP_POS    = 4'd1;
    localparam t_step STEP_RD0    = 4'd2;
    localparam t_step STEP_RD1    = 4'd3;
    localparam t_step STEP_DIFF   = 4'd4;
    localparam t_step STEP_INTERP = 4'd5;
    localparam t_step STEP_DLY    = 4'd6;
    localparam t_step STEP_FB     = 4'd7;
    localparam t_step STEP_STORE  = 4'd8;
    localparam t_step STEP_WRITE  = 4'd9;
    localparam t_step STEP_OUT    = 4'd10;
    localparam t_step STEP_LAST   = STEP_OUT;

    typedef struct packed {
        t_seq_op  seq;
        t_rd_sel  rd;
        t_mul_sel mul;
        t_alu_op  alu;
        logic     wr;
        t_step    target;
    } t_ctrl;

    // Program ROM: one control word per step.
    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w = '{seq: SEQ_NEXT, rd: RD_NONE, mul: MUL_NONE, alu: ALU_NOP,
              wr: 1'b0, target: STEP_IDLE};
        case (step)
            STEP_IDLE: begin
                w.seq = SEQ_WAIT_IN;
                w.alu = ALU_LATCH;
            end
            STEP_POS: begin
                w.alu = ALU_POS;
            end
            STEP_RD0: begin
                w.rd  = RD_I0;
                w.alu = ALU_I1;
            end
            STEP_RD1: begin
                w.rd  = RD_I1;
                w.alu = ALU_D0;
            end
            STEP_DIFF: begin
                w.alu = ALU_DIFF;
            end
            STEP_INTERP: begin
                w.mul = MUL_INTERP;
            end
            STEP_DLY: begin
                w.alu = ALU_DLY;
            end
            STEP_FB: begin
                w.mul = MUL_FB;
            end
            STEP_STORE: begin
                w.alu = ALU_STORE;
                w.mul = MUL_DRY;
            end
            STEP_WRITE: begin
                w.wr  = 1'b1;
                w.alu = ALU_ACC;
                w.mul = MUL_WET;
            end
            STEP_OUT: begin
                w.seq    = SEQ_WAIT_OUT;
                w.alu    = ALU_OUT;
                w.target = STEP_IDLE;
            end
            default: begin
                w.seq    = SEQ_JUMP;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [PROD_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[SAMPLE_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ffd_in_if.sv =====
interface ffd_in_if import ffd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CH_IN_W-1:0]         channel;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink (input valid, input channel, input sample_in, output ready);
endinterface

// ===== rtl/ffd_out_if.sv =====
interface ffd_out_if import ffd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

// ===== rtl/fractional_feedback_delay_unit.sv =====
// Channel   Dir  Handshake            Payload
// i_in      in   valid / ready        channel[2:0], sample_in[23:0] signed
// o_out     out  valid / ready        sample_out[23:0] signed
// APB       in   psel/penable/pwrite  paddr[3:0], pwdata[31:0], prdata[31:0]
//
// Each word runs an eleven-step microcode program, so a new input word is taken
// only once the previous word has run through it; the two ring reads share one
// read port and the four multiplies share one multiplier, one step each.
// The result sits in an output register; the program holds at its last step only
// while a previous result has not been taken yet.
// Synchronous reset clears the write pointers, the per-channel wrap flags, the
// sequencer and the output valid; ring entries not written since reset read as zero.
module fractional_feedback_delay_unit import ffd_pkg::*; #(
    parameter int BUF_DEPTH    = 4096,
    parameter int NUM_CHANNELS = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ffd_in_if.sink             i_in,
    ffd_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int TOTAL  = NUM_CHANNELS * BUF_DEPTH;
    localparam int ADDR_W = $clog2(TOTAL);

    t_cfg                       cfg;
    t_ctrl                      ctrl;
    logic                       out_free;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic signed [SAMPLE_W-1:0] rd_data;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic signed [SAMPLE_W-1:0] wr_data;

    ffd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ffd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .o_ctrl     (ctrl),
        .o_in_ready (i_in.ready)
    );

    ffd_dp #(
        .BUF_DEPTH    (BUF_DEPTH),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_cfg        (cfg),
        .i_channel    (i_in.channel),
        .i_sample_in  (i_in.sample_in),
        .i_out_ready  (o_out.ready),
        .o_out_free   (out_free),
        .o_out_valid  (o_out.valid),
        .o_sample_out (o_out.sample_out),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    ffd_ring #(
        .DEPTH (TOTAL)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule

// ===== rtl/ffd_regs.sv =====
module ffd_regs import ffd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [DELAY_W-1:0] r_delay;
    logic [FB_W-1:0]    r_fb;
    logic [MIX_W-1:0]   r_mix;
    logic [1:0]         reg_idx;
    logic [FB_W-1:0]    fb_wr;
    logic [MIX_W-1:0]   mix_wr;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;

    assign fb_wr  = (pwdata[FB_W-1:0] > FB_MAX) ? FB_MAX : pwdata[FB_W-1:0];
    assign mix_wr = (pwdata[MIX_W-1:0] > MIX_MAX) ? MIX_MAX : pwdata[MIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= '0;
            r_fb    <= '0;
            r_mix   <= MIX_W'(16384);
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_DELAY: r_delay <= pwdata[DELAY_W-1:0];
                REG_FB:    r_fb    <= fb_wr;
                REG_MIX:   r_mix   <= mix_wr;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DELAY: prdata = PDATA_W'(r_delay);
            REG_FB:    prdata = PDATA_W'(r_fb);
            REG_MIX:   prdata = PDATA_W'(r_mix);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = '{delay: r_delay, fb: r_fb, mix: r_mix};

endmodule

// ===== rtl/ffd_seq.sv =====
module ffd_seq import ffd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    output t_ctrl o_ctrl,
    output logic  o_in_ready
);

    t_step r_step;
    t_step n_step;
    t_ctrl word;
    logic  go;

    assign word = ucode(r_step);

    always_comb begin
        case (word.seq)
            SEQ_NEXT:     go = 1'b1;
            SEQ_WAIT_IN:  go = i_in_valid;
            SEQ_WAIT_OUT: go = i_out_free;
            SEQ_JUMP:     go = 1'b1;
            default:      go = 1'b0;
        endcase
    end

    always_comb begin
        if (!go) begin
            n_step = r_step;
        end else if (word.seq == SEQ_WAIT_OUT || word.seq == SEQ_JUMP) begin
            n_step = word.target;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    // A step whose condition is not met issues no datapath operation.
    always_comb begin
        o_ctrl = word;
        if (!go) begin
            o_ctrl.rd  = RD_NONE;
            o_ctrl.mul = MUL_NONE;
            o_ctrl.alu = ALU_NOP;
            o_ctrl.wr  = 1'b0;
        end
    end

    assign o_in_ready = (word.seq == SEQ_WAIT_IN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_LAST)
        else $error("sequencer step beyond program end");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_step == STEP_POS))
        else $error("accepted word did not start the program");

    a_out_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (word.seq == SEQ_WAIT_OUT && i_out_free) |=> (r_step == STEP_IDLE))
        else $error("program did not return to idle after result");

endmodule

// ===== rtl/ffd_ring.sv =====
module ffd_ring import ffd_pkg::*; #(
    parameter  int DEPTH  = 8192,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic signed [SAMPLE_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic signed [SAMPLE_W-1:0] i_wr_data
);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/ffd_dp.sv =====
module ffd_dp import ffd_pkg::*; #(
    parameter  int BUF_DEPTH    = 4096,
    parameter  int NUM_CHANNELS = 2,
    localparam int ADDR_W       = $clog2(NUM_CHANNELS * BUF_DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_ctrl                      i_ctrl,
    input  t_cfg                       i_cfg,
    input  logic [CH_IN_W-1:0]         i_channel,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic                       i_out_ready,
    output logic                       o_out_free,
    output logic                       o_out_valid,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_rd_en,
    output logic [ADDR_W-1:0]          o_rd_addr,
    input  logic signed [SAMPLE_W-1:0] i_rd_data,
    output logic                       o_wr_en,
    output logic [ADDR_W-1:0]          o_wr_addr,
    output logic signed [SAMPLE_W-1:0] o_wr_data
);

    localparam int PTR_W = $clog2(BUF_DEPTH);
    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int TOTAL = NUM_CHANNELS * BUF_DEPTH;
    localparam int DC_W  = PTR_W + FRAC_W;
    localparam int PW    = PTR_W + FRAC_W + 2;
    localparam int DMAX  = (BUF_DEPTH - 2) * (2 ** FRAC_W);

    // Per-channel write pointer and a flag set once the ring has wrapped.
    // Writes go strictly in order from entry zero, so an entry has been
    // written since reset exactly when it lies below the pointer or the
    // ring has wrapped; other entries read as zero.
    logic [PTR_W-1:0] r_wp      [NUM_CHANNELS];
    logic             r_wrapped [NUM_CHANNELS];

    logic [CH_W-1:0]            r_ch;
    logic signed [SAMPLE_W-1:0] r_x;
    logic [DC_W-1:0]            r_dc;
    logic [ADDR_W-1:0]          r_base;
    logic [PTR_W-1:0]           r_wp_cur;
    logic                       r_wrap_cur;
    logic [PTR_W-1:0]           r_i0;
    logic [PTR_W-1:0]           r_i1;
    logic [FRAC_W-1:0]          r_f;
    logic                       r_v0;
    logic                       r_v1;
    logic signed [SAMPLE_W-1:0] r_d0;
    logic signed [DIFF_W-1:0]   r_diff;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_dly;
    logic signed [SAMPLE_W-1:0] r_st;
    logic signed [PROD_W-1:0]   r_acc;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out;

    logic [CH_W-1:0]            ch_cl;
    logic [DC_W-1:0]            dc_next;
    logic signed [PW-1:0]       pos_a;
    logic signed [PW-1:0]       pos_b;
    logic signed [PW-1:0]       pos;
    logic signed [SAMPLE_W-1:0] d1;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [PROD_W-1:0]   dly_sum;
    logic signed [PROD_W-1:0]   st_sum;
    logic signed [PROD_W-1:0]   mix_sum;

    always_comb begin
        if ({1'b0, i_channel} >= (CH_IN_W + 1)'(NUM_CHANNELS)) begin
            ch_cl = CH_W'(NUM_CHANNELS - 1);
        end else begin
            ch_cl = CH_W'(i_channel);
        end
    end

    assign dc_next = (32'(i_cfg.delay) > 32'(DMAX)) ? DC_W'(DMAX) : DC_W'(i_cfg.delay);

    // Read position with wrap into the ring, in 1/256 sample units.
    assign pos_a = $signed({2'b00, r_wp_cur, {FRAC_W{1'b0}}}) - $signed({2'b00, r_dc});
    assign pos_b = pos_a + PW'(BUF_DEPTH * (2 ** FRAC_W));
    assign pos   = pos_a[PW-1] ? pos_b : pos_a;

    assign d1 = r_v1 ? i_rd_data : '0;

    always_comb begin
        case (i_ctrl.mul)
            MUL_INTERP: begin
                mul_a = MUL_A_W'(r_diff);
                mul_b = MUL_B_W'(r_f);
            end
            MUL_FB: begin
                mul_a = MUL_A_W'(r_dly);
                mul_b = MUL_B_W'(i_cfg.fb);
            end
            MUL_DRY: begin
                mul_a = MUL_A_W'(r_x);
                mul_b = MUL_B_W'(MUL_B_W'(32768) - MUL_B_W'(i_cfg.mix));
            end
            MUL_WET: begin
                mul_a = MUL_A_W'(r_dly);
                mul_b = MUL_B_W'(i_cfg.mix);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign dly_sum = (PROD_W'(r_d0) <<< FRAC_W) + r_prod + RND8;
    assign st_sum  = PROD_W'(r_x) + ((r_prod + RND15) >>> 15);
    assign mix_sum = (r_acc + r_prod + RND15) >>> 15;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.alu)
            ALU_LATCH: begin
                r_ch       <= ch_cl;
                r_x        <= i_sample_in;
                r_dc       <= dc_next;
                r_base     <= ADDR_W'(int'(ch_cl) * BUF_DEPTH);
                r_wp_cur   <= r_wp[ch_cl];
                r_wrap_cur <= r_wrapped[ch_cl];
            end
            ALU_POS: begin
                r_i0 <= pos[PTR_W+FRAC_W-1:FRAC_W];
                r_f  <= pos[FRAC_W-1:0];
            end
            ALU_I1: begin
                r_i1 <= (r_i0 == PTR_W'(BUF_DEPTH - 1)) ? '0 : r_i0 + PTR_W'(1);
            end
            ALU_D0: begin
                r_d0 <= r_v0 ? i_rd_data : '0;
            end
            ALU_DIFF: begin
                r_diff <= DIFF_W'(d1) - DIFF_W'(r_d0);
            end
            ALU_DLY: begin
                r_dly <= dly_sum[SAMPLE_W+FRAC_W-1:FRAC_W];
            end
            ALU_STORE: begin
                r_st <= sat24(st_sum);
            end
            ALU_ACC: begin
                r_acc <= r_prod;
            end
            ALU_OUT: begin
                r_out <= sat24(mix_sum);
            end
            default: begin
            end
        endcase

        if (i_ctrl.mul != MUL_NONE) begin
            r_prod <= mul_p;
        end

        r_v0 <= r_wrap_cur || (r_i0 < r_wp_cur);
        r_v1 <= r_wrap_cur || (r_i1 < r_wp_cur);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_wp[c]      <= '0;
                r_wrapped[c] <= 1'b0;
            end
        end else if (i_ctrl.wr) begin
            if (r_wp_cur == PTR_W'(BUF_DEPTH - 1)) begin
                r_wp[r_ch]      <= '0;
                r_wrapped[r_ch] <= 1'b1;
            end else begin
                r_wp[r_ch] <= r_wp_cur + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.alu == ALU_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rd_en   = (i_ctrl.rd != RD_NONE);
    assign o_rd_addr = r_base + ADDR_W'((i_ctrl.rd == RD_I1) ? r_i1 : r_i0);
    assign o_wr_en   = i_ctrl.wr;
    assign o_wr_addr = r_base + ADDR_W'(r_wp_cur);
    assign o_wr_data = r_st;

    assign o_out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (32'(o_wr_addr) < 32'(TOTAL)))
        else $error("ring write outside memory");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.alu == ALU_OUT) |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_ctrl.alu == ALU_OUT))
        else $error("output valid raised without a result");

endmodule
